/* design/ffq_pkg.sv */
// ---------------------------------------------------------------------------
// ffq_pkg
// Shared codes for the ticket queue: opcodes, status codes, cell commands.
// ---------------------------------------------------------------------------
package ffq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_CAN  = 2'd2,
    OP_LIST = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CMD_NOP = 3'd0,
    CMD_ENQ = 3'd1,
    CMD_DEQ = 3'd2,
    CMD_CAN = 3'd3,
    CMD_ROT = 3'd4
  } cmd_e;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RID_W    = 16;
  localparam int unsigned PEND_W   = 5;

endpackage

/* design/ffq_cell.sv */
// ---------------------------------------------------------------------------
// ffq_cell
// One queue slot: holds an id, compares it against the cancel key and
// takes its neighbour's id when the entries in front of it close up.
// ---------------------------------------------------------------------------
module ffq_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                                 clk_i,
  input  ffq_pkg::cmd_e                        cmd_i,
  input  logic [ID_BITS-1:0]                   id_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     occ_i,
  input  logic                                 hit_i,
  output logic                                 hit_o,
  input  logic [ID_BITS-1:0]                   next_i,
  input  logic [ID_BITS-1:0]                   head_i,
  output logic [ID_BITS-1:0]                   data_o
);
  import ffq_pkg::*;

  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] POS  = OW'(IDX);
  localparam logic [OW-1:0] POS1 = OW'(IDX + 1);

  logic [ID_BITS-1:0] data_q, data_d;
  logic               used;

  assign used   = POS < occ_i;
  assign hit_o  = hit_i | (used && (data_q == id_i));
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    case (cmd_i)
      CMD_ENQ: if (POS == occ_i) data_d = id_i;
      CMD_DEQ: if (used) data_d = next_i;
      CMD_CAN: if (used && hit_o) data_d = next_i;
      CMD_ROT: begin
        if (POS1 == occ_i) data_d = head_i;
        else if (used) data_d = next_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

/* design/fifo_queue_with_cancel.sv */
// ---------------------------------------------------------------------------
// fifo_queue_with_cancel
// Bounded FIFO of ticket ids with enqueue, dequeue, cancel by id and list.
// ---------------------------------------------------------------------------
// Input channel: opcode_i / ticket_id_i, word taken when in_valid_i is high
// and in_stall_o is low. Output channel: status_o, result_id_o, last_o,
// pending_count_o, word taken when out_valid_o is high and out_stall_i low.
// The queue is a chain of cells, front at cell 0; every cell compares its id
// with the cancel key in the same cycle and the cells behind the removed one
// shift forward, so one enqueue, dequeue or cancel may be accepted every
// cycle while the output register drains; the result word is registered and
// appears in the cycle after the input word is accepted.
// List: acceptance sets the list flag; then the chain rotates by one cell
// per word, the head id is loaded as each word, one word per cycle while the
// output does not stall, for N pending ids, and the input is stalled until
// the last one is loaded. After N rotations the order is back as it was.
// Reset empties the queue; stored ids are not cleared.
// When the receiver stalls, the output word holds and the input stalls once
// the output register is full.
// ---------------------------------------------------------------------------
module fifo_queue_with_cancel #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [15:0]                    ticket_id_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ffq_pkg::STATUS_W-1:0]   status_o,
  output logic [ffq_pkg::RID_W-1:0]      result_id_o,
  output logic                           last_o,
  output logic [ffq_pkg::PEND_W-1:0]     pending_count_o
);
  import ffq_pkg::*;

  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] FULL_CNT = OW'(QUEUE_DEPTH);

  logic [OW-1:0]      occ_q, occ_d, cnt;
  logic [OW-1:0]      rem_q, rem_d;
  logic               list_q, list_d;
  logic               out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [RID_W-1:0]   rid_q;
  logic               last_q;
  logic [PEND_W-1:0]  pend_q;

  logic               take, out_ready, ld, last;
  status_e            st;
  logic [RID_W-1:0]   rid;
  cmd_e               cmd;
  logic [ID_BITS-1:0] key;
  logic               empty, found;

  logic [ID_BITS-1:0] data [QUEUE_DEPTH];
  logic               hit  [QUEUE_DEPTH+1];

  assign key       = ID_BITS'(ticket_id_i);
  assign empty     = occ_q == '0;
  assign found     = hit[QUEUE_DEPTH];
  assign out_ready = !out_valid_q || !out_stall_i;
  assign in_stall_o = list_q || !out_ready;
  assign take      = in_valid_i && !in_stall_o;
  assign hit[0]    = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] nxt;
    if (g == QUEUE_DEPTH - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = data[g+1];
    end
    ffq_cell #(
      .IDX        (g),
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS    (ID_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .cmd_i (cmd),
      .id_i  (key),
      .occ_i (occ_q),
      .hit_i (hit[g]),
      .hit_o (hit[g+1]),
      .next_i(nxt),
      .head_i(data[0]),
      .data_o(data[g])
    );
  end

  always_comb begin
    cmd    = CMD_NOP;
    ld     = 1'b0;
    st     = ST_OK;
    rid    = '0;
    last   = 1'b1;
    cnt    = occ_q;
    occ_d  = occ_q;
    list_d = list_q;
    rem_d  = rem_q;
    if (list_q) begin
      if (out_ready) begin
        cmd    = CMD_ROT;
        ld     = 1'b1;
        rid    = RID_W'(data[0]);
        last   = rem_q == OW'(1);
        rem_d  = rem_q - OW'(1);
        list_d = rem_q != OW'(1);
      end
    end else if (take) begin
      ld = 1'b1;
      case (op_e'(opcode_i))
        OP_ENQ: begin
          if (occ_q == FULL_CNT) begin
            st = ST_FULL;
          end else begin
            cmd   = CMD_ENQ;
            rid   = RID_W'(key);
            occ_d = occ_q + OW'(1);
          end
        end
        OP_DEQ: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            cmd   = CMD_DEQ;
            rid   = RID_W'(data[0]);
            occ_d = occ_q - OW'(1);
          end
        end
        OP_CAN: begin
          if (empty) begin
            st = ST_EMPTY;
          end else if (!found) begin
            st = ST_NOTFOUND;
          end else begin
            cmd   = CMD_CAN;
            rid   = RID_W'(key);
            occ_d = occ_q - OW'(1);
          end
        end
        OP_LIST: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            ld     = 1'b0;
            list_d = 1'b1;
            rem_d  = occ_q;
          end
        end
        default: ld = 1'b0;
      endcase
      cnt = occ_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rem_q       <= '0;
      list_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      rem_q  <= rem_d;
      list_q <= list_d;
      if (ld) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      status_q <= st;
      rid_q    <= rid;
      last_q   <= last;
      pend_q   <= PEND_W'(cnt);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_id_o     = rid_q;
  assign last_o          = last_q;
  assign pending_count_o = pend_q;

endmodule

/* design/ffq_checker.sv */
// ---------------------------------------------------------------------------
// ffq_checker
// Port-level checks on the ticket queue, bound to the top level.
// ---------------------------------------------------------------------------
module ffq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ffq_pkg::STATUS_W-1:0]   status_o,
  input logic [ffq_pkg::RID_W-1:0]      result_id_o,
  input logic                           last_o,
  input logic [ffq_pkg::PEND_W-1:0]     pending_count_o
);
  import ffq_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_id_o)
      && $stable(status_o) && $stable(last_o))
    else $error("stalled output word changed");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_id_o == '0 && last_o)
    else $error("error word with id or without last");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> pending_count_o == PEND_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> pending_count_o == '0)
    else $error("empty status with tickets pending");

  // a word short of last means the list has words still to load
  a_list_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a list");

endmodule

bind fifo_queue_with_cancel ffq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ffq_checker (.*);
